### rtl/sfcc_pkg.sv
// Package for the sensor frame CRC check and conversion block.
// Holds the frame kinds, field widths, conversion constants and the CRC-8 byte update.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sfcc_pkg;

  // Frame kinds carried on the input tuser
  typedef enum logic [1:0] {
    KIND_TEMP  = 2'd0,
    KIND_HUMID = 2'd1,
    KIND_REG   = 2'd2,
    KIND_SPARE = 2'd3
  } frame_kind_e;

  // Field widths
  localparam int unsigned KindW    = 2;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned RawW     = 16;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned ScaledW  = 15;
  localparam int unsigned GainW    = 15;
  localparam int unsigned ProductW = GainW + RawW;

  // Packed bus widths (output padded to whole bytes)
  localparam int unsigned InDataW   = 3 * ByteW;
  localparam int unsigned OutFieldW = RawW + StatusW + ScaledW + 1;
  localparam int unsigned OutDataW  = ((OutFieldW + 7) / 8) * 8;

  // CRC-8, polynomial x^8+x^5+x^4+1, init 0, MSB first
  localparam logic [ByteW-1:0] CrcPoly = 8'h31;
  localparam logic [ByteW-1:0] CrcInit = 8'h00;

  // Status bits live in the two low bits of the measurement
  localparam logic [RawW-1:0] StatusMask = 16'h0003;

  // Fixed-point conversion: scaled = floor(gain * S / 2^16) - offset
  localparam logic [GainW-1:0]   TempGain    = 15'd17572;
  localparam logic [GainW-1:0]   HumidGain   = 15'd12500;
  localparam logic [ScaledW-1:0] TempOffset  = 15'd4685;
  localparam logic [ScaledW-1:0] HumidOffset = 15'd600;

  // Output range, for checking
  localparam logic signed [ScaledW-1:0] ScaledMin = -15'sd4685;
  localparam logic signed [ScaledW-1:0] ScaledMax = 15'sd12885;

  // One byte through the CRC, one bit per step
  function automatic logic [ByteW-1:0] crc8_update(input logic [ByteW-1:0] crc,
                                                   input logic [ByteW-1:0] data);
    logic [ByteW-1:0] c;
    c = crc ^ data;
    for (int k = 0; k < ByteW; k++) begin
      if (c[ByteW-1]) begin
        c = {c[ByteW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[ByteW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/sensor_frame_crc_and_convert.sv
// Sensor reply frame checker and converter: top level.
// Depends on sfcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

// One frame per transaction in, one result per transaction out. Frames are
// registered at the input, the CRC-8 check (poly 0x31, init 0, MSB first) and
// the fixed-point conversion run in one combinational pass, and the result is
// held in an output register. The result is valid once the frame has passed
// through the input and the output register; throughput is one frame per clock
// while m_axis_tready allows it, set by that single pass. A stored frame moves on
// only when the output register can take it, but one more frame is taken into an
// empty input register while a finished result waits for m_axis_tready. Kind 3 is treated as a register byte.
module sensor_frame_crc_and_convert
  import sfcc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Input frames
  input  wire logic                 s_axis_tvalid,
  output      logic                 s_axis_tready,
  // [7:0] first_byte, [15:8] second_byte, [23:16] received_crc
  input  wire logic [InDataW-1:0]   s_axis_tdata,
  // [1:0] frame_kind
  input  wire logic [KindW-1:0]     s_axis_tuser,
  // Results
  output      logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // [15:0] raw_value, [17:16] status_bits, [32:18] scaled_value,
  // [33] crc_mismatch, [39:34] zero
  output      logic [OutDataW-1:0]  m_axis_tdata
);

  // Input register
  logic              in_valid_q;
  logic [KindW-1:0]  kind_q;
  logic [ByteW-1:0]  b0_q, b1_q, rx_q;
  logic              in_ready;
  logic              out_ready;

  // Result register
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign in_ready      = !in_valid_q || out_ready;
  assign s_axis_tready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid) begin
      kind_q <= s_axis_tuser;
      b0_q   <= s_axis_tdata[ByteW-1:0];
      b1_q   <= s_axis_tdata[2*ByteW-1:ByteW];
      rx_q   <= s_axis_tdata[3*ByteW-1:2*ByteW];
    end
  end

  // Conversion and CRC check
  frame_kind_e                 kind;
  logic [ByteW-1:0]            crc_first, crc_both, crc_calc;
  logic [RawW-1:0]             meas;
  logic [RawW-1:0]             raw_value;
  logic [StatusW-1:0]          status_bits;
  logic [GainW-1:0]            gain;
  logic [ScaledW-1:0]          offset;
  logic [ProductW-1:0]         product;
  logic [ScaledW-1:0]          scaled_value;
  logic                        crc_mismatch;
  logic                        is_meas;

  always_comb begin
    kind        = frame_kind_e'(kind_q);
    crc_first   = crc8_update(CrcInit, b0_q);
    crc_both    = crc8_update(crc_first, b1_q);
    meas        = {b0_q, b1_q} & ~StatusMask;
    is_meas     = 1'b0;
    gain        = TempGain;
    offset      = TempOffset;
    unique case (kind)
      KIND_TEMP: begin
        is_meas = 1'b1;
        gain    = TempGain;
        offset  = TempOffset;
      end
      KIND_HUMID: begin
        is_meas = 1'b1;
        gain    = HumidGain;
        offset  = HumidOffset;
      end
      KIND_REG, KIND_SPARE: begin
        is_meas = 1'b0;
      end
      default: begin
        is_meas = 1'b0;
      end
    endcase
    product = ProductW'(gain) * ProductW'(meas);
    if (is_meas) begin
      crc_calc     = crc_both;
      raw_value    = meas;
      status_bits  = b1_q[StatusW-1:0];
      scaled_value = product[ProductW-1:RawW] - offset;
    end else begin
      crc_calc     = crc_first;
      raw_value    = RawW'(b0_q);
      status_bits  = '0;
      scaled_value = '0;
    end
    crc_mismatch = (crc_calc != rx_q);
    out_data_d   = OutDataW'({crc_mismatch, scaled_value, status_bits, raw_value});
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && in_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

### rtl/sfcc_checker.sv
// Port-level checks for sensor_frame_crc_and_convert, attached by bind.
// Depends on sfcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfcc_checker
  import sfcc_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic [InDataW-1:0]  s_axis_tdata,
  input wire logic [KindW-1:0]    s_axis_tuser,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OutDataW-1:0] m_axis_tdata
);

  logic [RawW-1:0]           raw_value;
  logic [StatusW-1:0]        status_bits;
  logic signed [ScaledW-1:0] scaled_value;

  assign raw_value    = m_axis_tdata[RawW-1:0];
  assign status_bits  = m_axis_tdata[RawW+StatusW-1:RawW];
  assign scaled_value = m_axis_tdata[RawW+StatusW+ScaledW-1:RawW+StatusW];

  // A stalled result holds its transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // The input only backs up when the output is full and stalled
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled with free output");

  // Nonzero status only comes with a measurement, whose low bits are cleared
  a_status_meas: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && status_bits != '0 |-> raw_value[StatusW-1:0] == '0)
    else $error("status bits with uncleared raw value");

  // Converted value stays within the sensor range
  a_scaled_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> scaled_value >= ScaledMin && scaled_value <= ScaledMax)
    else $error("scaled value out of range");

  // Nothing is lost when both sides are active: input ready in the same cycle
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output ready");

  logic unused_in;
  assign unused_in = s_axis_tvalid ^ (^s_axis_tdata) ^ (^s_axis_tuser);

endmodule

bind sensor_frame_crc_and_convert sfcc_checker u_sfcc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### tb/sv/testbench.sv
// Testbench for sensor_frame_crc_and_convert: directed and random sensor frames,
// a local CRC-8 and fixed-point predictor, and an in-order result checker.
// Depends on sfcc_pkg and the RTL of the block.
`timescale 1ns / 1ps

module testbench;
  import sfcc_pkg::*;

  // Local prediction constants
  localparam logic [7:0]  Crc8Poly     = 8'h31;
  localparam int unsigned TempScale    = 17572;
  localparam int unsigned HumidScale   = 12500;
  localparam int          TempBias     = 4685;
  localparam int          HumidBias    = 600;
  localparam int unsigned DutLatency   = 2;
  localparam realtime     RunLimit     = 2_000_000ns;

  // One expected conversion result
  typedef struct {
    logic [15:0]        raw;
    logic [1:0]         status;
    logic signed [14:0] scaled;
    logic               mismatch;
  } sensor_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [KindW-1:0]    s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  sensor_result_t pending_results[$];
  int unsigned    err_count = 0;
  int unsigned    src_idle_pct = 0;
  int unsigned    sink_idle_pct = 0;

  sensor_frame_crc_and_convert dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock, 8 ns period
  initial begin
    forever #4ns clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #RunLimit;
    $display("DONE: errors detected");
    $finish;
  end

  // CRC-8 over the data bytes, bit-serial, MSB first
  function automatic logic [7:0] frame_crc(frame_kind_e kind, logic [7:0] b0, logic [7:0] b1);
    logic [15:0] bits;
    int          nbits;
    logic [7:0]  c;
    logic        fb;
    c = 8'h00;
    if (kind == KIND_TEMP || kind == KIND_HUMID) begin
      bits  = {b0, b1};
      nbits = 16;
    end else begin
      bits  = {b0, 8'h00};
      nbits = 8;
    end
    for (int i = 0; i < nbits; i++) begin
      fb = c[7] ^ bits[15-i];
      c  = {c[6:0], 1'b0} ^ (fb ? Crc8Poly : 8'h00);
    end
    return c;
  endfunction

  // Expected result of one frame
  function automatic sensor_result_t convert_frame(frame_kind_e kind, logic [7:0] b0,
                                                   logic [7:0] b1, logic [7:0] rx_crc);
    sensor_result_t res;
    logic [15:0]    meas;
    logic [31:0]    prod;
    int             value;
    res.status = 2'b00;
    res.scaled = '0;
    res.mismatch = (frame_crc(kind, b0, b1) != rx_crc);
    if (kind == KIND_TEMP || kind == KIND_HUMID) begin
      meas = {b0, b1[7:2], 2'b00};
      res.raw = meas;
      res.status = b1[1:0];
      if (kind == KIND_TEMP) begin
        prod  = TempScale * meas;
        value = int'(prod[31:16]) - TempBias;
      end else begin
        prod  = HumidScale * meas;
        value = int'(prod[31:16]) - HumidBias;
      end
      res.scaled = value[14:0];
    end else begin
      res.raw = {8'h00, b0};
    end
    return res;
  endfunction

  // Drive one frame and record its expected result once accepted.
  // Valid stays high after the transaction; it drops on a gap or in drain_results.
  task automatic send_frame(frame_kind_e kind, logic [7:0] b0, logic [7:0] b1,
                            logic [7:0] rx_crc);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {rx_crc, b1, b0};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(convert_frame(kind, b0, b1, rx_crc));
  endtask

  // Stop sending and wait until every expected result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Edge values, every kind, good and bad checksums
  task automatic test_corner_frames();
    logic [7:0] good;
    logic [7:0] meas_bytes[6][2] = '{'{8'h00, 8'h00}, '{8'hFF, 8'hFF}, '{8'h80, 8'h01},
                                     '{8'h7F, 8'hFE}, '{8'hAA, 8'h57}, '{8'h55, 8'hAA}};
    for (int i = 0; i < 6; i++) begin
      good = frame_crc(KIND_TEMP, meas_bytes[i][0], meas_bytes[i][1]);
      send_frame(KIND_TEMP, meas_bytes[i][0], meas_bytes[i][1], (i % 2) ? ~good : good);
      send_frame(KIND_HUMID, meas_bytes[i][0], meas_bytes[i][1], (i % 2) ? good : good ^ 8'h01);
    end
    // register byte: second byte must not matter
    send_frame(KIND_REG, 8'h00, 8'hFF, frame_crc(KIND_REG, 8'h00, 8'h00));
    send_frame(KIND_REG, 8'hFF, 8'h00, frame_crc(KIND_REG, 8'hFF, 8'h00));
    send_frame(KIND_REG, 8'h3A, 8'hC5, 8'hFF);
    // unused kind behaves as a register byte
    send_frame(KIND_SPARE, 8'h00, 8'h00, 8'h00);
    send_frame(KIND_SPARE, 8'hFF, 8'hFF, frame_crc(KIND_SPARE, 8'hFF, 8'h00));
    send_frame(KIND_SPARE, 8'h5C, 8'h13, 8'h80);
    drain_results();
  endtask

  // Random frames, mostly measurements with valid checksums
  task automatic run_random_frames(int unsigned count);
    frame_kind_e kind;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  rx_crc;
    int unsigned pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(9);
      kind = (pick < 4) ? KIND_TEMP : (pick < 8) ? KIND_HUMID : (pick == 8) ? KIND_REG : KIND_SPARE;
      b0 = 8'($urandom());
      b1 = 8'($urandom());
      if ($urandom_range(9) == 0) b0 = $urandom_range(1) ? 8'hFF : 8'h00;
      if ($urandom_range(9) == 0) b1 = $urandom_range(1) ? 8'hFF : 8'h00;
      rx_crc = ($urandom_range(3) != 0) ? frame_crc(kind, b0, b1) : 8'($urandom());
      send_frame(kind, b0, b1, rx_crc);
    end
    drain_results();
  endtask

  task automatic test_source_gaps();
    src_idle_pct  = 31;
    sink_idle_pct = 75;
    run_random_frames(310);
  endtask

  task automatic test_sink_backpressure();
    src_idle_pct  = 75;
    sink_idle_pct = 31;
    run_random_frames(310);
  endtask

  task automatic test_full_rate();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_random_frames(310);
  endtask

  // Receiver stalls
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, m_axis_tdata);
        err_count++;
      end else begin
        sensor_result_t exp_res;
        exp_res = pending_results.pop_front();
        if (m_axis_tdata[15:0] !== exp_res.raw) begin
          $display("%0t: raw_value expected %h, got %h", $time, exp_res.raw,
                   m_axis_tdata[15:0]);
          err_count++;
        end
        if (m_axis_tdata[17:16] !== exp_res.status) begin
          $display("%0t: status_bits expected %h, got %h", $time, exp_res.status,
                   m_axis_tdata[17:16]);
          err_count++;
        end
        if (m_axis_tdata[32:18] !== exp_res.scaled) begin
          $display("%0t: scaled_value expected %0d, got %0d", $time, exp_res.scaled,
                   $signed(m_axis_tdata[32:18]));
          err_count++;
        end
        if (m_axis_tdata[33] !== exp_res.mismatch) begin
          $display("%0t: crc_mismatch expected %b, got %b", $time, exp_res.mismatch,
                   m_axis_tdata[33]);
          err_count++;
        end
        if (m_axis_tdata[OutDataW-1:34] !== '0) begin
          $display("%0t: padding expected 0, got %h", $time, m_axis_tdata[OutDataW-1:34]);
          err_count++;
        end
      end
    end
  end

  // Test sequence
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_frames();
    test_source_gaps();
    test_sink_backpressure();
    test_full_rate();
    repeat (DutLatency + 6) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sensor_frame_crc_and_convert.f
rtl/sfcc_pkg.sv
rtl/sensor_frame_crc_and_convert.sv
rtl/sfcc_checker.sv
tb/sv/testbench.sv
